// ===== hdl/kbc_pkg.sv =====
package kbc_pkg;

  localparam int FIFO_DEPTH_DEF = 8;
  localparam int HELD_SLOTS_DEF = 8;

  localparam int KEY_W  = 8;
  localparam int WORD_W = 16;

  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_CMD  = 2'd2;

  localparam logic [WORD_W-1:0] CMD_CLEAR   = 16'd0;
  localparam logic [WORD_W-1:0] CMD_POP     = 16'd1;
  localparam logic [WORD_W-1:0] CMD_TEST    = 16'd2;
  localparam logic [WORD_W-1:0] CMD_SET_MSG = 16'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [KEY_W-1:0]  key_code;
    logic [WORD_W-1:0] command;
    logic [WORD_W-1:0] operand;
  } item_t;

  typedef struct packed {
    logic              read_valid;
    logic [WORD_W-1:0] read_data;
    logic              irq_valid;
    logic [WORD_W-1:0] irq_message;
  } result_t;

endpackage

// ===== hdl/kbc_in_stage.sv =====
module kbc_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,   // key_code, command, operand
  input  logic [1:0]    in_tuser,   // kind
  input  logic          advance,
  output logic          item_valid,
  output kbc_pkg::item_t item
);
  import kbc_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind     <= in_tuser;
      item_r.key_code <= in_tdata[7:0];
      item_r.command  <= in_tdata[23:8];
      item_r.operand  <= in_tdata[39:24];
    end
  end

endmodule

// ===== hdl/kbc_core.sv =====
module kbc_core #(
  parameter int FIFO_DEPTH = kbc_pkg::FIFO_DEPTH_DEF,
  parameter int HELD_SLOTS = kbc_pkg::HELD_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  kbc_pkg::item_t   item,
  output kbc_pkg::result_t result
);
  import kbc_pkg::*;

  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int FIW = $clog2(FIFO_DEPTH);
  localparam int SIW = $clog2(HELD_SLOTS);

  logic [KEY_W-1:0]  fifo_r [FIFO_DEPTH];
  logic [KEY_W-1:0]  fifo_nxt [FIFO_DEPTH];
  logic [KEY_W-1:0]  fifo_sh [FIFO_DEPTH];
  logic [CW-1:0]     count_r, count_nxt;
  logic [KEY_W-1:0]  held_r [HELD_SLOTS];
  logic [KEY_W-1:0]  held_nxt [HELD_SLOTS];
  logic [WORD_W-1:0] msg_r, msg_nxt;
  logic              free_found;
  logic [SIW-1:0]    free_idx;
  logic              test_hit;

  always_comb begin
    for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
      fifo_sh[i] = fifo_r[i + 1];
    end
    fifo_sh[FIFO_DEPTH-1] = fifo_r[FIFO_DEPTH-1];
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    test_hit   = 1'b0;
    for (int i = 0; i < HELD_SLOTS; i++) begin
      if (!free_found && held_r[i] == '0) begin
        free_found = 1'b1;
        free_idx   = SIW'(i);
      end
      if (held_r[i] == item.operand[7:0]) begin
        test_hit = 1'b1;
      end
    end
  end

  always_comb begin
    fifo_nxt  = fifo_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    msg_nxt   = msg_r;
    result    = '0;
    case (item.kind)
      KIND_DOWN: begin
        held_nxt[free_idx] = item.key_code;
        if (count_r < CW'(FIFO_DEPTH)) begin
          fifo_nxt[count_r[FIW-1:0]] = item.key_code;
          count_nxt = count_r + CW'(1);
        end else begin
          fifo_nxt = fifo_sh;
          fifo_nxt[FIFO_DEPTH-1] = item.key_code;
        end
        if (msg_r != '0) begin
          result.irq_valid   = 1'b1;
          result.irq_message = msg_r;
        end
      end
      KIND_UP: begin
        if (item.key_code != '0) begin
          for (int i = 0; i < HELD_SLOTS; i++) begin
            if (held_r[i] == item.key_code) begin
              held_nxt[i] = '0;
            end
          end
        end
        if (msg_r != '0) begin
          result.irq_valid   = 1'b1;
          result.irq_message = msg_r;
        end
      end
      KIND_CMD: begin
        unique case (item.command)
          CMD_CLEAR: begin
            count_nxt = '0;
          end
          CMD_POP: begin
            result.read_valid = 1'b1;
            if (count_r != '0) begin
              result.read_data = {{(WORD_W-KEY_W){1'b0}}, fifo_r[0]};
              fifo_nxt  = fifo_sh;
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_TEST: begin
            result.read_valid = 1'b1;
            result.read_data  = {{(WORD_W-1){1'b0}},
                                 (item.operand != '0) && (item.operand[15:8] == '0) && test_hit};
          end
          CMD_SET_MSG: begin
            msg_nxt = item.operand;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        fifo_r[i] <= '0;
      end
      for (int i = 0; i < HELD_SLOTS; i++) begin
        held_r[i] <= '0;
      end
      count_r <= '0;
      msg_r   <= '0;
    end else if (fire) begin
      fifo_r  <= fifo_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      msg_r   <= msg_nxt;
    end
  end

endmodule

// ===== hdl/kbc_out_stage.sv =====
module kbc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  kbc_pkg::result_t result,
  output logic             advance,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // read_data, irq_message
  output logic [1:0]       out_tuser   // read_valid, irq_valid
);
  import kbc_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign advance    = item_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = {result_r.irq_message, result_r.read_data};
  assign out_tuser  = {result_r.irq_valid, result_r.read_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

endmodule

// ===== hdl/keyboard_controller.sv =====
// Keyboard controller for a 16-bit CPU.
// Input channel: one transaction per key event or CPU command. in_tuser carries
// the kind (key down, key up, command); in_tdata carries key_code, command and
// operand. Result channel: exactly one transaction per input transaction, in
// order. out_tuser flags a register C answer and an interrupt; out_tdata
// carries read_data and irq_message (each zero when its flag is low).
// Path: each input transaction is held in the input register, and its result
// is captured in the result register.
// Throughput: one transaction per cycle while out_tready is high; the held-slot
// scan, the typed-key shift and all state updates are combinational between
// the input register and the result register.
// Reset: the typed-key FIFO and held slots are zeroed, the count is cleared
// and interrupts are off; both channels come up empty.
// Stall: while out_tready is low the result register holds, the input register
// holds its item, and in_tready drops once both are full. No transaction is
// lost or repeated.
module keyboard_controller #(
  parameter int FIFO_DEPTH = kbc_pkg::FIFO_DEPTH_DEF,
  parameter int HELD_SLOTS = kbc_pkg::HELD_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key_code[7:0], command[23:8], operand[39:24]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data[15:0], irq_message[31:16]
  output logic [1:0]  out_tuser   // read_valid[0], irq_valid[1]
);
  import kbc_pkg::*;

  logic    item_valid;
  logic    advance;
  item_t   item;
  result_t result;

  kbc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  kbc_core #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .HELD_SLOTS (HELD_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item),
    .result (result)
  );

  kbc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
